>>> hdl/sofi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sofi_pkg;

    // Default table size
    localparam int TABLE_DEPTH_DEF = 1024;

    // Field widths
    localparam int KEY_W    = 32;
    localparam int BASE_W   = 63;
    localparam int OFFSET_W = 64;
    localparam int COUNT_W  = 11;

    // Operation codes
    typedef enum logic [1:0] {
        OP_APPEND   = 2'd0,
        OP_LOOKUP   = 2'd1,
        OP_TRUNCATE = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_POSITION = 3'd2,
        ST_ORDER    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // One table entry: relative offset and byte position
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] pos;
    } entry_t;

    // Decoded request, held while the sequencer works on it
    typedef struct packed {
        op_t              op;
        logic             above;    // offset at or above the segment base
        logic             big;      // relative offset beyond 32 bits
        logic [KEY_W-1:0] rel;      // low 32 bits of the relative offset
        logic             pos_big;  // byte position beyond 32 bits
        logic [KEY_W-1:0] pos;
    } req_t;

endpackage

`default_nettype wire

>>> hdl/sofi_mem.sv
`timescale 1ns / 1ps
`default_nettype none

// Entry table: one write port, one read port, registered read data
module sofi_mem #(
    parameter int TABLE_DEPTH = sofi_pkg::TABLE_DEPTH_DEF,
    localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output sofi_pkg::entry_t      rd_data,
    input  wire logic             wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire sofi_pkg::entry_t wr_data
);

    sofi_pkg::entry_t mem [TABLE_DEPTH];
    sofi_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/sofi_decode.sv
`timescale 1ns / 1ps
`default_nettype none

// Captures a request and works out its relative offset and range flags
module sofi_decode (
    input  wire logic                                   clk,
    input  wire logic                                   accept,
    input  wire logic [1:0]                             operation,
    input  wire logic signed [sofi_pkg::OFFSET_W-1:0]   record_offset,
    input  wire logic [sofi_pkg::OFFSET_W-1:0]          byte_position,
    input  wire logic [sofi_pkg::BASE_W-1:0]            base,
    output sofi_pkg::req_t                              req
);

    logic [sofi_pkg::OFFSET_W-1:0] diff;
    sofi_pkg::req_t                req_next;
    sofi_pkg::req_t                req_reg;

    // Exact offset minus base; the top bit flags a borrow
    assign diff = {1'b0, record_offset[sofi_pkg::OFFSET_W-2:0]} - {1'b0, base};

    always_comb
    begin
        req_next.op      = sofi_pkg::op_t'(operation);
        req_next.above   = !record_offset[sofi_pkg::OFFSET_W-1] && !diff[sofi_pkg::OFFSET_W-1];
        req_next.big     = (diff[sofi_pkg::OFFSET_W-2:sofi_pkg::KEY_W] != '0);
        req_next.rel     = diff[sofi_pkg::KEY_W-1:0];
        req_next.pos_big = (byte_position[sofi_pkg::OFFSET_W-1:sofi_pkg::KEY_W] != '0);
        req_next.pos     = byte_position[sofi_pkg::KEY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

    assign req = req_reg;

endmodule

`default_nettype wire

>>> hdl/sorted_offset_floor_index_core.sv
`timescale 1ns / 1ps
`default_nettype none

// One request at a time. The binary search makes one table read per cycle through
// the memory's read port.
// Reset clears the entry count and segment base; the table memory is not cleared,
// and no entry beyond the count is ever read.
module sorted_offset_floor_index_core #(
    parameter int TABLE_DEPTH = sofi_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration
    input  wire logic                                 segment_base_we,
    input  wire logic [sofi_pkg::BASE_W-1:0]          segment_base,
    // request channel
    input  wire logic                                 in_valid,
    output      logic                                 in_stall,
    input  wire logic [1:0]                           operation,
    input  wire logic signed [sofi_pkg::OFFSET_W-1:0] record_offset,
    input  wire logic [sofi_pkg::OFFSET_W-1:0]        byte_position,
    // result channel
    output      logic                                 out_valid,
    input  wire logic                                 out_stall,
    output      logic [2:0]                           status,
    output      logic                                 found,
    output      logic [sofi_pkg::KEY_W-1:0]           hit_relative,
    output      logic [sofi_pkg::KEY_W-1:0]           hit_position,
    output      logic [sofi_pkg::COUNT_W-1:0]         entry_count
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int EXT_W  = CNT_W + sofi_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_APPEND = 6'b000100,
        S_SEARCH = 6'b001000,
        S_FETCH  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [sofi_pkg::BASE_W-1:0] base_reg;
    logic [CNT_W-1:0]            fill_reg, fill_next;
    logic [CNT_W-1:0]            lo_reg, lo_next;
    logic [CNT_W-1:0]            hi_reg, hi_next;
    logic [CNT_W-1:0]            mid_reg, mid_next;

    sofi_pkg::status_t           res_status_reg, res_status_next;
    logic                        res_found_reg, res_found_next;
    sofi_pkg::entry_t            res_entry_reg, res_entry_next;

    logic                        out_valid_reg, out_valid_next;
    logic [2:0]                  out_status_reg;
    logic                        out_found_reg;
    logic [sofi_pkg::KEY_W-1:0]  out_rel_reg;
    logic [sofi_pkg::KEY_W-1:0]  out_pos_reg;
    logic [sofi_pkg::COUNT_W-1:0] out_count_reg;
    logic                        out_load;

    logic                        accept;
    sofi_pkg::req_t              req;

    logic                        rd_en;
    logic [ADDR_W-1:0]           rd_addr;
    sofi_pkg::entry_t            rd_data;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    sofi_pkg::entry_t            wr_data;

    logic                        go_right;
    logic [CNT_W-1:0]            lo_step, hi_step, mid_step, mid_init;
    logic [CNT_W-1:0]            fill_m1, lo_step_m1;
    logic [EXT_W-1:0]            fill_ext;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // Request capture and range checks
    sofi_decode u_decode (
        .clk           (clk),
        .accept        (accept),
        .operation     (operation),
        .record_offset (record_offset),
        .byte_position (byte_position),
        .base          (base_reg),
        .req           (req)
    );

    // Entry table
    sofi_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // One binary search step on the entry just read at mid
    always_comb
    begin
        if (req.op == sofi_pkg::OP_LOOKUP)
        begin
            go_right = (rd_data.key <= req.rel);
        end
        else
        begin
            go_right = (rd_data.key < req.rel);
        end
        lo_step    = go_right ? (mid_reg + CNT_W'(1)) : lo_reg;
        hi_step    = go_right ? hi_reg : mid_reg;
        mid_step   = lo_step + ((hi_step - lo_step) >> 1);
        mid_init   = fill_reg >> 1;
        fill_m1    = fill_reg - CNT_W'(1);
        lo_step_m1 = lo_step - CNT_W'(1);
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_entry_next  = res_entry_reg;
        rd_en           = 1'b0;
        rd_addr         = fill_m1[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = fill_reg[ADDR_W-1:0];
        wr_data.key     = req.rel;
        wr_data.pos     = req.pos;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = sofi_pkg::ST_OK;
                    res_found_next  = 1'b0;
                    res_entry_next  = '0;
                    state_next      = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_DONE;
                case (req.op)
                    sofi_pkg::OP_APPEND:
                    begin
                        if (!req.above || req.big)
                        begin
                            res_status_next = sofi_pkg::ST_RANGE;
                        end
                        else if (req.pos_big)
                        begin
                            res_status_next = sofi_pkg::ST_POSITION;
                        end
                        else if (fill_reg != '0)
                        begin
                            // fetch the last entry for the order check
                            rd_en      = 1'b1;
                            state_next = S_APPEND;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end

                    sofi_pkg::OP_LOOKUP:
                    begin
                        if (fill_reg != '0 && req.above)
                        begin
                            if (req.big)
                            begin
                                // target past 32 bits: last entry
                                rd_en      = 1'b1;
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = fill_reg;
                                mid_next   = mid_init;
                                rd_en      = 1'b1;
                                rd_addr    = mid_init[ADDR_W-1:0];
                                state_next = S_SEARCH;
                            end
                        end
                    end

                    sofi_pkg::OP_TRUNCATE:
                    begin
                        if (!req.above)
                        begin
                            fill_next = '0;
                        end
                        else if (!req.big && fill_reg != '0)
                        begin
                            lo_next    = '0;
                            hi_next    = fill_reg;
                            mid_next   = mid_init;
                            rd_en      = 1'b1;
                            rd_addr    = mid_init[ADDR_W-1:0];
                            state_next = S_SEARCH;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_APPEND:
            begin
                state_next = S_DONE;
                if (rd_data.key >= req.rel)
                begin
                    res_status_next = sofi_pkg::ST_ORDER;
                end
                else if (fill_reg == FULL_CNT)
                begin
                    res_status_next = sofi_pkg::ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                end
            end

            S_SEARCH:
            begin
                lo_next  = lo_step;
                hi_next  = hi_step;
                mid_next = mid_step;
                if (lo_step < hi_step)
                begin
                    rd_en   = 1'b1;
                    rd_addr = mid_step[ADDR_W-1:0];
                end
                else if (req.op == sofi_pkg::OP_LOOKUP)
                begin
                    if (lo_step != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = lo_step_m1[ADDR_W-1:0];
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    // truncate: keep the entries below the offset
                    if (lo_step < fill_reg)
                    begin
                        fill_next = lo_step;
                    end
                    state_next = S_DONE;
                end
            end

            S_FETCH:
            begin
                res_found_next = 1'b1;
                res_entry_next = rd_data;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    assign fill_ext = EXT_W'(fill_reg);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_rel_reg    <= res_entry_reg.key;
            out_pos_reg    <= res_entry_reg.pos;
            out_count_reg  <= fill_ext[sofi_pkg::COUNT_W-1:0];
        end
    end

    // Search and result payload
    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_entry_reg  <= res_entry_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (segment_base_we)
            begin
                base_reg <= segment_base;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign found        = out_found_reg;
    assign hit_relative = out_rel_reg;
    assign hit_position = out_pos_reg;
    assign entry_count  = out_count_reg;

endmodule

`default_nettype wire
